FILE: hw/rtl/cmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared constants for the counting multiset table.
// ----------------------------------------------------------------------------
package cmt_pkg;
  localparam int ENTRIES_DEF    = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KEY_W   = 32;
  localparam int OCC_W   = 16;
  localparam int TOTAL_W = 22;
  localparam int DIST_W  = 7;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;
endpackage

FILE: hw/rtl/cmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/counting_multiset_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_multiset_table_top
// Multiset of 32-bit elements held as keys with occurrence counts.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The input is not ready again until the result of
// the accepted beat has been written to the output register. Each item takes
// one pass that reads every slot through the key/count RAM port to find a
// match, the lowest free slot and the current mode, followed by a write-back
// state (S_WB). The mode is then recomputed by comparing the updated slot
// against the scan results in the S_MODE state.
// A new item is taken while a finished result still waits at the output; the
// next result then holds in the S_OUT state, with the input stalled, until
// the output register is free.
// Used bits live in flip-flops and are cleared by reset; key and count RAMs
// need no clearing pass.
module counting_multiset_table_top #(
  parameter int ENTRIES    = cmt_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = cmt_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // command[1:0], element[33:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata   // status[1:0], found[2], occurrences[18:3],
                                // total_items[40:19], distinct_items[47:41],
                                // is_empty[48], mode_valid[49],
                                // mode_element[81:50], zero pad
);
  localparam int AW = $clog2(ENTRIES);
  localparam int KW = cmt_pkg::KEY_W;
  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_MODE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state;
  logic [1:0]    cmd;
  logic [KW-1:0] key;
  logic [ENTRIES-1:0] used;
  logic [AW-1:0] raddr, rslot;    // rslot: slot whose data is on rdata
  logic          rvalid;
  logic [KW-1:0] key_rd;
  logic [CW-1:0] cnt_rd;
  logic          hit_ok, free_ok;
  logic [AW-1:0] hit_idx, free_idx;
  logic [CW-1:0] hit_cnt;
  // mode over all slots except the hit slot (which gets updated)
  logic          bm_ok;
  logic [CW-1:0] bm_cnt;
  logic [AW-1:0] bm_idx;
  logic [KW-1:0] bm_key;
  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wcnt;
  logic [1:0]    status;
  logic          found;
  logic [CW-1:0] occ;
  logic          upd_ok;          // target slot used after the step
  logic [AW-1:0] upd_idx;
  logic [CW-1:0] upd_cnt;
  logic [cmt_pkg::TOTAL_W-1:0] total;
  logic [cmt_pkg::DIST_W-1:0]  distinct;
  logic          mode_ok;
  logic [KW-1:0] mode_key;
  logic [87:0]   obuf;
  logic          ovalid;

  cmt_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key (
    .clk(clk), .we(we), .waddr(waddr), .wdata(key), .raddr(raddr), .rdata(key_rd)
  );
  cmt_ram #(.WIDTH(CW), .DEPTH(ENTRIES)) u_cnt (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wcnt), .raddr(raddr), .rdata(cnt_rd)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = ovalid;
  assign m_tdata  = obuf;

  logic slot_used_rd, is_hit;
  assign slot_used_rd = used[rslot];
  assign is_hit = rvalid && slot_used_rd && (key_rd == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      total    <= '0;
      distinct <= '0;
      ovalid   <= 1'b0;
      we       <= 1'b0;
      rvalid   <= 1'b0;
    end else begin
      we <= 1'b0;
      if (ovalid && m_tready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd     <= s_tdata[1:0];
            key     <= s_tdata[33:2];
            raddr   <= '0;
            rvalid  <= 1'b0;
            hit_ok  <= 1'b0;
            free_ok <= 1'b0;
            bm_ok   <= 1'b0;
            bm_cnt  <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          rslot  <= raddr;
          rvalid <= (state == S_SCAN);
          if (state == S_SCAN) begin
            if (raddr == AW'(ENTRIES - 1)) begin
              state <= S_LAST;
            end else begin
              raddr <= raddr + 1'b1;
            end
          end else begin
            state <= S_WB;
          end
          if (rvalid) begin
            if (is_hit) begin
              hit_ok  <= 1'b1;
              hit_idx <= rslot;
              hit_cnt <= cnt_rd;
            end else if (slot_used_rd && cnt_rd > bm_cnt) begin
              bm_ok  <= 1'b1;
              bm_cnt <= cnt_rd;
              bm_idx <= rslot;
              bm_key <= key_rd;
            end
            if (!slot_used_rd && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= rslot;
            end
          end
        end
        S_WB: begin
          rvalid  <= 1'b0;
          status  <= cmt_pkg::ST_OK;
          found   <= hit_ok;
          occ     <= hit_ok ? hit_cnt : '0;
          upd_ok  <= hit_ok;
          upd_idx <= hit_idx;
          upd_cnt <= hit_cnt;
          if (cmd == cmt_pkg::CMD_ADD) begin
            if (hit_ok) begin
              if (hit_cnt == CMAX) begin
                status <= cmt_pkg::ST_SAT;
              end else begin
                we      <= 1'b1;
                waddr   <= hit_idx;
                wcnt    <= hit_cnt + 1'b1;
                occ     <= hit_cnt + 1'b1;
                upd_cnt <= hit_cnt + 1'b1;
                total   <= total + 1'b1;
              end
            end else if (!free_ok) begin
              status <= cmt_pkg::ST_FULL;
            end else begin
              we             <= 1'b1;
              waddr          <= free_idx;
              wcnt           <= CW'(1);
              used[free_idx] <= 1'b1;
              found          <= 1'b1;
              occ            <= CW'(1);
              upd_ok         <= 1'b1;
              upd_idx        <= free_idx;
              upd_cnt        <= CW'(1);
              total          <= total + 1'b1;
              distinct       <= distinct + 1'b1;
            end
          end else if (cmd == cmt_pkg::CMD_REMOVE) begin
            if (hit_ok) begin
              we      <= 1'b1;
              waddr   <= hit_idx;
              wcnt    <= hit_cnt - 1'b1;
              occ     <= hit_cnt - 1'b1;
              upd_cnt <= hit_cnt - 1'b1;
              total   <= total - 1'b1;
              if (hit_cnt == CW'(1)) begin
                used[hit_idx] <= 1'b0;
                distinct      <= distinct - 1'b1;
                found         <= 1'b0;
                occ           <= '0;
                upd_ok        <= 1'b0;
              end
            end else begin
              status <= cmt_pkg::ST_ABSENT;
            end
          end else if (!hit_ok) begin
            status <= cmt_pkg::ST_ABSENT;
          end
          state <= S_MODE;
        end
        S_MODE: begin
          // merge updated slot with best of the rest; lower slot wins ties
          if (upd_ok && (!bm_ok || upd_cnt > bm_cnt ||
                         (upd_cnt == bm_cnt && upd_idx < bm_idx))) begin
            mode_ok  <= 1'b1;
            mode_key <= key;
          end else begin
            mode_ok  <= bm_ok;
            mode_key <= bm_ok ? bm_key : '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid || m_tready) begin
            obuf <= {6'd0, mode_key, mode_ok, (total == '0), distinct, total,
                     cmt_pkg::OCC_W'(occ), found, status};
            ovalid <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
